// File: src/i2cm_pkg.sv
`default_nettype none

package i2cm_pkg;

  localparam int unsigned PHASE_W = 16;
  localparam int unsigned POLL_W  = 10;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BIT_CNT_W = 4;

  localparam logic [PHASE_W-1:0]   PHASE_TICKS_RESET = 16'd2;
  localparam logic [POLL_W-1:0]    ACK_LIMIT_RESET   = 10'd100;
  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE     = 4'd8;

  typedef enum logic [0:0] {
    REG_PHASE_TICKS = 1'b0,
    REG_ACK_LIMIT   = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    STEP_IDLE   = 5'd0,
    STEP_ST_A   = 5'd1,
    STEP_ST_B   = 5'd2,
    STEP_ST_C   = 5'd3,
    STEP_SP_A   = 5'd4,
    STEP_SP_B   = 5'd5,
    STEP_SP_C   = 5'd6,
    STEP_WR_LO  = 5'd7,
    STEP_WR_HI  = 5'd8,
    STEP_AK_LO  = 5'd9,
    STEP_AK_HI  = 5'd10,
    STEP_AK_END = 5'd11,
    STEP_RD_LO  = 5'd12,
    STEP_RD_HI  = 5'd13,
    STEP_RA_LO  = 5'd14,
    STEP_RA_HI  = 5'd15,
    STEP_RA_END = 5'd16
  } step_t;

  // One classified tick as it travels from the front queue to the sequencer.
  typedef struct packed {
    logic              load;
    cmd_t              cmd;
    logic [BYTE_W-1:0] wdata;
    logic              send_ack;
    logic              sda;
  } tick_t;

  // One result beat.
  typedef struct packed {
    logic              scl;
    logic              sda;
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] rdata;
    logic              timeout;
  } res_t;

endpackage

`default_nettype wire

// File: src/i2cm_front.sv
`default_nettype none

module i2cm_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic                         command_valid,
  input  wire i2cm_pkg::cmd_t               command,
  input  wire logic [i2cm_pkg::BYTE_W-1:0]  write_data,
  input  wire logic                         send_ack,
  input  wire logic                         sda_in,
  output logic                              q_valid,
  output i2cm_pkg::tick_t                   q_item,
  input  wire logic                         q_pop
);
  import i2cm_pkg::*;

  tick_t       slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push_ok;
  logic        pop_ok;
  tick_t       classified;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item  = slot[rd_ptr];
  assign push_ok = push && !full;
  assign pop_ok  = q_pop && q_valid;

  // Classify: fold the offer flag into the command record.
  always_comb begin
    classified.load     = command_valid;
    classified.cmd      = command;
    classified.wdata    = write_data;
    classified.send_ack = send_ack;
    classified.sda      = sda_in;
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) wr_ptr <= ~wr_ptr;
      if (pop_ok)  rd_ptr <= ~rd_ptr;
      unique case ({push_ok, pop_ok})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/i2cm_seq.sv
`default_nettype none

module i2cm_seq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire i2cm_pkg::reg_index_t          cfg_index,
  input  wire logic [i2cm_pkg::PHASE_W-1:0]  cfg_data,
  input  wire logic                          in_valid,
  input  wire i2cm_pkg::tick_t               in_item,
  output logic                               in_pop,
  input  wire logic                          res_ready,
  output logic                               res_push,
  output i2cm_pkg::res_t                     res_item
);
  import i2cm_pkg::*;

  logic [PHASE_W-1:0]   phase_ticks;
  logic [POLL_W-1:0]    ack_timeout_limit;

  step_t                sequence_step, sequence_step_next;
  logic [BIT_CNT_W-1:0] bit_count, bit_count_next;
  logic [BYTE_W-1:0]    shift_byte, shift_byte_next;
  logic [PHASE_W-1:0]   phase_count, phase_count_next;
  logic [POLL_W-1:0]    poll_count, poll_count_next;
  logic                 scl_level, scl_level_next;
  logic                 sda_level, sda_level_next;
  logic                 ack_choice, ack_choice_next;
  logic                 timeout_flag, timeout_flag_next;
  logic [BYTE_W-1:0]    received_byte, received_byte_next;

  logic [PHASE_W-1:0]   eff_ticks;
  logic                 go;
  logic                 enter_step;
  step_t                target;

  // Pin levels {scl, sda} held during a phase.
  function automatic logic [1:0] step_pins(step_t s, logic msb, logic ack_sel,
                                           logic [1:0] hold);
    logic [1:0] p;
    unique case (s)
      STEP_ST_A:   p = 2'b11;
      STEP_ST_B:   p = 2'b10;
      STEP_ST_C:   p = 2'b00;
      STEP_SP_A:   p = 2'b00;
      STEP_SP_B:   p = 2'b10;
      STEP_SP_C:   p = 2'b11;
      STEP_WR_LO:  p = {1'b0, msb};
      STEP_WR_HI:  p = {1'b1, msb};
      STEP_AK_LO:  p = 2'b01;
      STEP_AK_HI:  p = 2'b11;
      STEP_AK_END: p = 2'b01;
      STEP_RD_LO:  p = 2'b01;
      STEP_RD_HI:  p = 2'b11;
      STEP_RA_LO:  p = {1'b0, ~ack_sel};
      STEP_RA_HI:  p = {1'b1, ~ack_sel};
      STEP_RA_END: p = 2'b01;
      default:     p = hold;
    endcase
    return p;
  endfunction

  assign go        = in_valid && res_ready;
  assign in_pop    = go;
  assign res_push  = go;
  assign eff_ticks = (phase_ticks == '0) ? PHASE_W'(1) : phase_ticks;

  always_comb begin
    sequence_step_next = sequence_step;
    bit_count_next     = bit_count;
    shift_byte_next    = shift_byte;
    phase_count_next   = phase_count;
    poll_count_next    = poll_count;
    scl_level_next     = scl_level;
    sda_level_next     = sda_level;
    ack_choice_next    = ack_choice;
    timeout_flag_next  = timeout_flag;
    received_byte_next = received_byte;
    enter_step         = 1'b0;
    target             = STEP_IDLE;
    res_item           = '0;

    // Load a command offered while idle; this tick is the first of its phase.
    if (sequence_step == STEP_IDLE && in_item.load) begin
      bit_count_next = '0;
      unique case (in_item.cmd)
        CMD_START: sequence_step_next = STEP_ST_A;
        CMD_STOP:  sequence_step_next = STEP_SP_A;
        CMD_WRITE: begin
          shift_byte_next    = in_item.wdata;
          timeout_flag_next  = 1'b0;
          sequence_step_next = STEP_WR_LO;
        end
        CMD_READ: begin
          shift_byte_next    = '0;
          ack_choice_next    = in_item.send_ack;
          sequence_step_next = STEP_RD_LO;
        end
        default: sequence_step_next = STEP_IDLE;
      endcase
      phase_count_next = '0;
      {scl_level_next, sda_level_next} = step_pins(sequence_step_next,
          shift_byte_next[BYTE_W-1], ack_choice_next, {scl_level, sda_level});
    end

    res_item.scl = scl_level_next;
    res_item.sda = sda_level_next;

    if (sequence_step_next != STEP_IDLE) begin
      res_item.busy    = 1'b1;
      phase_count_next = phase_count_next + PHASE_W'(1);
      if (phase_count_next >= eff_ticks) begin
        enter_step = 1'b1;
        unique case (sequence_step_next)
          STEP_ST_A:  target = STEP_ST_B;
          STEP_ST_B:  target = STEP_ST_C;
          STEP_SP_A:  target = STEP_SP_B;
          STEP_SP_B:  target = STEP_SP_C;
          STEP_WR_LO: target = STEP_WR_HI;
          STEP_WR_HI: begin
            shift_byte_next = {shift_byte_next[BYTE_W-2:0], 1'b0};
            bit_count_next  = bit_count_next + BIT_CNT_W'(1);
            if (bit_count_next >= BITS_PER_BYTE) begin
              poll_count_next = '0;
              target          = STEP_AK_LO;
            end else begin
              target = STEP_WR_LO;
            end
          end
          STEP_AK_LO: target = STEP_AK_HI;
          STEP_AK_HI: begin
            if (!in_item.sda) begin
              target = STEP_AK_END;
            end else if (poll_count_next >= ack_timeout_limit) begin
              timeout_flag_next = 1'b1;
              target            = STEP_SP_A;
            end else begin
              poll_count_next = poll_count_next + POLL_W'(1);
              target          = STEP_AK_HI;
            end
          end
          STEP_RD_LO: target = STEP_RD_HI;
          STEP_RD_HI: begin
            shift_byte_next = {shift_byte_next[BYTE_W-2:0], in_item.sda};
            bit_count_next  = bit_count_next + BIT_CNT_W'(1);
            target = (bit_count_next >= BITS_PER_BYTE) ? STEP_RA_LO : STEP_RD_LO;
          end
          STEP_RA_LO: target = STEP_RA_HI;
          STEP_RA_HI: target = STEP_RA_END;
          STEP_RA_END: begin
            received_byte_next = shift_byte_next;
            enter_step         = 1'b0;
          end
          default: enter_step = 1'b0;
        endcase
        phase_count_next = '0;
        if (enter_step) begin
          sequence_step_next = target;
          {scl_level_next, sda_level_next} = step_pins(target,
              shift_byte_next[BYTE_W-1], ack_choice_next, {scl_level, sda_level});
        end else begin
          sequence_step_next = STEP_IDLE;
          res_item.done      = 1'b1;
        end
      end
    end

    res_item.rdata   = received_byte_next;
    res_item.timeout = timeout_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks       <= PHASE_TICKS_RESET;
      ack_timeout_limit <= ACK_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PHASE_TICKS: phase_ticks       <= cfg_data;
        REG_ACK_LIMIT:   ack_timeout_limit <= cfg_data[POLL_W-1:0];
        default:         phase_ticks       <= phase_ticks;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_step <= STEP_IDLE;
      bit_count     <= '0;
      shift_byte    <= '0;
      phase_count   <= '0;
      poll_count    <= '0;
      scl_level     <= 1'b1;
      sda_level     <= 1'b1;
      ack_choice    <= 1'b0;
      timeout_flag  <= 1'b0;
      received_byte <= '0;
    end else if (go) begin
      sequence_step <= sequence_step_next;
      bit_count     <= bit_count_next;
      shift_byte    <= shift_byte_next;
      phase_count   <= phase_count_next;
      poll_count    <= poll_count_next;
      scl_level     <= scl_level_next;
      sda_level     <= sda_level_next;
      ack_choice    <= ack_choice_next;
      timeout_flag  <= timeout_flag_next;
      received_byte <= received_byte_next;
    end
  end

endmodule

`default_nettype wire

// File: src/i2cm_outq.sv
`default_nettype none

module i2cm_outq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire i2cm_pkg::res_t  wr_item,
  output logic                 wr_ready,
  output logic                 empty,
  input  wire logic            pop,
  output i2cm_pkg::res_t       head
);
  import i2cm_pkg::*;

  res_t        slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        wr_ok;
  logic        pop_ok;

  assign wr_ready = (count != 2'd2);
  assign empty    = (count == 2'd0);
  assign head     = slot[rd_ptr];
  assign wr_ok    = wr_en && wr_ready;
  assign pop_ok   = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      slot[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_ok)  wr_ptr <= ~wr_ptr;
      if (pop_ok) rd_ptr <= ~rd_ptr;
      unique case ({wr_ok, pop_ok})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/i2c_master_byte_engine_unit.sv
// Channel   | Handshake            | Beat contents
// ----------+----------------------+---------------------------------------------
// tick in   | push / full          | command_valid, command, write_data,
//           |                      | send_ack, sda_in
// result    | empty / pop          | scl_out, sda_out, busy_res, done_res,
//           |                      | read_data, ack_timeout
// config    | cfg_write            | cfg_index, cfg_data (no wait, no read-back)
//
// One tick beat per clock sustained while results are popped; each tick yields
// exactly one result beat. A tick lands in a two-entry front queue, and the
// sequencer retires one tick per clock into a two-entry result queue with room,
// so a result beat is registered in both queues before it reaches the ports.
// Synchronous reset empties both queues and parks the bus with SCL and SDA
// released; config registers return to 2 ticks per phase and ACK limit 100.
// A stalled pop holds the sequencer once the result queue fills; full rises
// after the front queue fills behind it.
`default_nettype none

module i2c_master_byte_engine_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          command_valid,
  input  wire i2cm_pkg::cmd_t                command,
  input  wire logic [i2cm_pkg::BYTE_W-1:0]   write_data,
  input  wire logic                          send_ack,
  input  wire logic                          sda_in,
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               scl_out,
  output logic                               sda_out,
  output logic                               busy_res,
  output logic                               done_res,
  output logic [i2cm_pkg::BYTE_W-1:0]        read_data,
  output logic                               ack_timeout,
  input  wire logic                          cfg_write,
  input  wire i2cm_pkg::reg_index_t          cfg_index,
  input  wire logic [i2cm_pkg::PHASE_W-1:0]  cfg_data
);
  import i2cm_pkg::*;

  logic  q_valid;
  tick_t q_item;
  logic  q_pop;
  logic  res_ready;
  logic  res_push;
  res_t  res_item;
  res_t  res_head;

  // Front: accept and classify ticks, hold them in a short queue.
  i2cm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .command_valid (command_valid),
    .command       (command),
    .write_data    (write_data),
    .send_ack      (send_ack),
    .sda_in        (sda_in),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // Back: bus phase sequencer, one tick per clock when both queues allow.
  i2cm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .in_pop    (q_pop),
    .res_ready (res_ready),
    .res_push  (res_push),
    .res_item  (res_item)
  );

  // Result queue: decouple the sequencer from a stalled consumer.
  i2cm_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_push),
    .wr_item  (res_item),
    .wr_ready (res_ready),
    .empty    (empty),
    .pop      (pop),
    .head     (res_head)
  );

  assign scl_out     = res_head.scl;
  assign sda_out     = res_head.sda;
  assign busy_res    = res_head.busy;
  assign done_res    = res_head.done;
  assign read_data   = res_head.rdata;
  assign ack_timeout = res_head.timeout;

endmodule

`default_nettype wire

// File: src/i2cm_checker.sv
`default_nettype none

module i2cm_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          push,
  input wire logic                          full,
  input wire logic                          empty,
  input wire logic                          pop,
  input wire logic                          scl_out,
  input wire logic                          sda_out,
  input wire logic                          busy_res,
  input wire logic                          done_res,
  input wire logic [i2cm_pkg::BYTE_W-1:0]   read_data,
  input wire logic                          ack_timeout
);
  import i2cm_pkg::*;

  // Both queues drain on reset.
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> empty && !full)
    else $error("result queue not empty after reset");

  // Hold the waiting result beat while it is not taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(scl_out) && $stable(sda_out) &&
      $stable(busy_res) && $stable(done_res) && $stable(read_data) &&
      $stable(ack_timeout)))
    else $error("waiting result beat changed");

  // A finishing tick is always a busy tick.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (!empty && done_res) |-> busy_res)
    else $error("done without busy");

  // The front queue fills only behind a pushed beat.
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("full rose without a push");

endmodule

bind i2c_master_byte_engine_unit i2cm_checker u_checker (.*);

`default_nettype wire

// File: tb/sv/i2cm_tick_checker.sv
`timescale 1ns / 1ps

module i2cm_tick_checker
  import i2cm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic               command_valid,
  input  cmd_t               command,
  input  logic [BYTE_W-1:0]  write_data,
  input  logic               send_ack,
  input  logic               sda_in,
  input  logic               empty,
  input  logic               pop,
  input  logic               scl_out,
  input  logic               sda_out,
  input  logic               busy_res,
  input  logic               done_res,
  input  logic [BYTE_W-1:0]  read_data,
  input  logic               ack_timeout,
  input  logic               cfg_write,
  input  reg_index_t         cfg_index,
  input  logic [PHASE_W-1:0] cfg_data,
  output int                 mismatches,
  output int                 pending
);

  logic [PHASE_W-1:0]   ticks_cfg;
  logic [POLL_W-1:0]    poll_limit;
  step_t                step;
  logic [BIT_CNT_W-1:0] nbits;
  logic [BYTE_W-1:0]    shift_q;
  logic [PHASE_W-1:0]   phase_cnt;
  logic [POLL_W-1:0]    polls;
  logic                 scl_lv;
  logic                 sda_lv;
  logic                 ack_sel;
  logic                 tmo;
  logic [BYTE_W-1:0]    rx_byte;

  res_t bus_result_q[$];
  int   err_count = 0;

  assign mismatches = err_count;

  function void reset_model();
    ticks_cfg  = PHASE_TICKS_RESET;
    poll_limit = ACK_LIMIT_RESET;
    step       = STEP_IDLE;
    nbits      = '0;
    shift_q    = '0;
    phase_cnt  = '0;
    polls      = '0;
    scl_lv     = 1'b1;
    sda_lv     = 1'b1;
    ack_sel    = 1'b0;
    tmo        = 1'b0;
    rx_byte    = '0;
  endfunction

  // Enter a bus phase and set the pin levels it holds.
  function void enter_step(input step_t s);
    logic data_bit;
    logic ack_lvl;
    data_bit  = shift_q[BYTE_W-1];
    ack_lvl   = ~ack_sel;
    step      = s;
    phase_cnt = '0;
    case (s)
      STEP_ST_A, STEP_SP_C, STEP_AK_HI, STEP_RD_HI: {scl_lv, sda_lv} = 2'b11;
      STEP_ST_B, STEP_SP_B:                         {scl_lv, sda_lv} = 2'b10;
      STEP_ST_C, STEP_SP_A:                         {scl_lv, sda_lv} = 2'b00;
      STEP_WR_LO:                                   {scl_lv, sda_lv} = {1'b0, data_bit};
      STEP_WR_HI:                                   {scl_lv, sda_lv} = {1'b1, data_bit};
      STEP_AK_LO, STEP_AK_END, STEP_RD_LO, STEP_RA_END: {scl_lv, sda_lv} = 2'b01;
      STEP_RA_LO:                                   {scl_lv, sda_lv} = {1'b0, ack_lvl};
      STEP_RA_HI:                                   {scl_lv, sda_lv} = {1'b1, ack_lvl};
      default:                                      step = STEP_IDLE;
    endcase
  endfunction

  // Close the current phase; returns 1 when the command is complete.
  function logic close_phase(input logic sda);
    close_phase = 1'b0;
    case (step)
      STEP_ST_A:  enter_step(STEP_ST_B);
      STEP_ST_B:  enter_step(STEP_ST_C);
      STEP_SP_A:  enter_step(STEP_SP_B);
      STEP_SP_B:  enter_step(STEP_SP_C);
      STEP_WR_LO: enter_step(STEP_WR_HI);
      STEP_WR_HI: begin
        shift_q = shift_q << 1;
        nbits   = nbits + 1'b1;
        if (nbits >= BITS_PER_BYTE) begin
          polls = '0;
          enter_step(STEP_AK_LO);
        end else begin
          enter_step(STEP_WR_LO);
        end
      end
      STEP_AK_LO: enter_step(STEP_AK_HI);
      STEP_AK_HI: begin
        if (!sda) begin
          enter_step(STEP_AK_END);
        end else if (polls >= poll_limit) begin
          tmo = 1'b1;
          enter_step(STEP_SP_A);
        end else begin
          polls = polls + 1'b1;
          enter_step(STEP_AK_HI);
        end
      end
      STEP_RD_LO: enter_step(STEP_RD_HI);
      STEP_RD_HI: begin
        shift_q = {shift_q[BYTE_W-2:0], sda};
        nbits   = nbits + 1'b1;
        if (nbits >= BITS_PER_BYTE) enter_step(STEP_RA_LO);
        else enter_step(STEP_RD_LO);
      end
      STEP_RA_LO: enter_step(STEP_RA_HI);
      STEP_RA_HI: enter_step(STEP_RA_END);
      STEP_RA_END: begin
        rx_byte     = shift_q;
        step        = STEP_IDLE;
        phase_cnt   = '0;
        close_phase = 1'b1;
      end
      default: begin
        step        = STEP_IDLE;
        phase_cnt   = '0;
        close_phase = 1'b1;
      end
    endcase
  endfunction

  // Advance the bus sequencer by one tick and return the levels it shows.
  function res_t predict_bus_tick(input logic valid, input cmd_t cmd,
                                  input logic [BYTE_W-1:0] wdata,
                                  input logic sack, input logic sda);
    res_t               r;
    logic [PHASE_W-1:0] span;
    span = (ticks_cfg == '0) ? PHASE_W'(1) : ticks_cfg;
    if (step == STEP_IDLE && valid) begin
      nbits = '0;
      case (cmd)
        CMD_START: enter_step(STEP_ST_A);
        CMD_STOP:  enter_step(STEP_SP_A);
        CMD_WRITE: begin
          shift_q = wdata;
          tmo     = 1'b0;
          enter_step(STEP_WR_LO);
        end
        default: begin
          shift_q = '0;
          ack_sel = sack;
          enter_step(STEP_RD_LO);
        end
      endcase
    end
    r.scl  = scl_lv;
    r.sda  = sda_lv;
    r.busy = 1'b0;
    r.done = 1'b0;
    if (step != STEP_IDLE) begin
      r.busy    = 1'b1;
      phase_cnt = phase_cnt + 1'b1;
      if (phase_cnt >= span) r.done = close_phase(sda);
    end
    r.rdata   = rx_byte;
    r.timeout = tmo;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [BYTE_W-1:0] want_v,
                             input logic [BYTE_W-1:0] got_v);
    if (want_v !== got_v) begin
      err_count++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      reset_model();
      bus_result_q.delete();
      pending <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_PHASE_TICKS: ticks_cfg = cfg_data;
          REG_ACK_LIMIT:   poll_limit = cfg_data[POLL_W-1:0];
          default: ;
        endcase
      end
      if (push && !full)
        bus_result_q.push_back(predict_bus_tick(command_valid, command, write_data,
                                                send_ack, sda_in));
      if (pop && !empty) begin
        if (bus_result_q.size() == 0) begin
          err_count++;
          $display("%0t: result beat with nothing expected: scl %b sda %b busy %b done %b",
                   $time, scl_out, sda_out, busy_res, done_res);
        end else begin
          want = bus_result_q.pop_front();
          check_field("scl_out", BYTE_W'(want.scl), BYTE_W'(scl_out));
          check_field("sda_out", BYTE_W'(want.sda), BYTE_W'(sda_out));
          check_field("busy_res", BYTE_W'(want.busy), BYTE_W'(busy_res));
          check_field("done_res", BYTE_W'(want.done), BYTE_W'(done_res));
          check_field("read_data", want.rdata, read_data);
          check_field("ack_timeout", BYTE_W'(want.timeout), BYTE_W'(ack_timeout));
        end
      end
      pending <= bus_result_q.size();
    end
  end

endmodule

// File: tb/sv/tb_i2c_master_byte_engine_unit.sv
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine_unit;
  import i2cm_pkg::*;

  // Give up after this many cycles in which neither side moves a beat.
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_TICKS = 220;

  logic               clk;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic               command_valid = 1'b0;
  cmd_t               command = CMD_START;
  logic [BYTE_W-1:0]  write_data = '0;
  logic               send_ack = 1'b0;
  logic               sda_in = 1'b1;
  logic               empty;
  logic               pop = 1'b0;
  logic               scl_out;
  logic               sda_out;
  logic               busy_res;
  logic               done_res;
  logic [BYTE_W-1:0]  read_data;
  logic               ack_timeout;
  logic               cfg_write = 1'b0;
  reg_index_t         cfg_index = REG_PHASE_TICKS;
  logic [PHASE_W-1:0] cfg_data = '0;

  int mismatches;
  int pending;
  int send_idle = 0;   // percent of cycles the tick source holds back
  int recv_stall = 0;  // percent of cycles the result side refuses a beat
  int sda_low_pct = 50;

  i2c_master_byte_engine_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .command_valid (command_valid),
    .command       (command),
    .write_data    (write_data),
    .send_ack      (send_ack),
    .sda_in        (sda_in),
    .empty         (empty),
    .pop           (pop),
    .scl_out       (scl_out),
    .sda_out       (sda_out),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .read_data     (read_data),
    .ack_timeout   (ack_timeout),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  i2cm_tick_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .command_valid (command_valid),
    .command       (command),
    .write_data    (write_data),
    .send_ack      (send_ack),
    .sda_in        (sda_in),
    .empty         (empty),
    .pop           (pop),
    .scl_out       (scl_out),
    .sda_out       (sda_out),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .read_data     (read_data),
    .ack_timeout   (ack_timeout),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Result side: one pop decision per edge, so pop never toggles twice in a step.
  always @(posedge clk) pop <= ($urandom_range(99) >= recv_stall);

  task automatic set_idling(input int s, input int r);
    send_idle = s;
    recv_stall <= r;
  endtask

  // Offer one tick beat and hold it until the block takes it. Gaps drop push
  // for whole cycles; push is never lowered and raised in the same step.
  task automatic send_tick(input logic v, input cmd_t c, input logic [BYTE_W-1:0] d,
                           input logic a, input logic s);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    command_valid <= v;
    command       <= c;
    write_data    <= d;
    send_ack      <= a;
    sda_in        <= s;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Issue a command, then pad with ticks holding SDA at a fixed level. The
  // first two pad ticks offer another command, which a busy block must drop.
  task automatic issue(input cmd_t c, input logic [BYTE_W-1:0] d, input logic a,
                       input logic s, input int pad);
    send_tick(1'b1, c, d, a, s);
    for (int i = 0; i < pad; i++)
      send_tick(i < 2, cmd_t'($urandom_range(3)), BYTE_W'($urandom),
                1'($urandom_range(1)), s);
  endtask

  // Random tick: commands offered now and then, SDA low at the phase's bias.
  task automatic random_tick();
    send_tick($urandom_range(99) < 25, cmd_t'($urandom_range(3)), BYTE_W'($urandom),
              1'($urandom_range(1)), $urandom_range(99) >= sda_low_pct);
  endtask

  // Hold the tick source until every expected result beat has been popped.
  // The first edge lets the checker's count catch up with the last push.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write both registers back to back; only call with nothing in flight.
  task automatic configure(input logic [PHASE_W-1:0] ticks, input logic [POLL_W-1:0] limit);
    cfg_write <= 1'b1;
    cfg_index <= REG_PHASE_TICKS;
    cfg_data  <= ticks;
    @(posedge clk);
    cfg_index <= REG_ACK_LIMIT;
    cfg_data  <= PHASE_W'(limit);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Watchdog: any beat on either side restarts the count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("tb_i2c_master_byte_engine_unit: errors");
    $finish;
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: a start at the reset settings, then every command at one tick
    // per phase, with byte extremes, both ACK choices and a timeout at limit 0.
    set_idling(33, 33);
    issue(CMD_START, 8'h00, 1'b0, 1'b1, 8);
    drain();
    configure(16'd1, 10'd0);
    issue(CMD_WRITE, 8'hFF, 1'b1, 1'b0, 20);   // slave ACKs on the first poll
    issue(CMD_WRITE, 8'h00, 1'b0, 1'b1, 24);   // no ACK: timeout and stop
    issue(CMD_READ,  8'h00, 1'b1, 1'b1, 21);   // read all ones, answer ACK
    issue(CMD_READ,  8'hFF, 1'b0, 1'b0, 21);   // read all zeros, answer NACK
    issue(CMD_STOP,  8'h00, 1'b0, 1'b1, 4);

    // Long ACK poll: 301 polls with SDA never pulled low, then timeout and stop.
    drain();
    set_idling(0, 0);
    configure(16'd1, 10'd300);
    issue(CMD_WRITE, 8'h5A, 1'b0, 1'b1, 330);

    // Widest phase length: run part of a 65535-tick start phase, then shorten
    // the phase mid-command so the already overdue phase ends on the next tick.
    drain();
    configure(16'hFFFF, 10'd7);
    issue(CMD_START, 8'h00, 1'b0, 1'b1, 30);
    drain();
    configure(16'd1, 10'd7);
    repeat (8) send_tick(1'b0, CMD_START, 8'h00, 1'b0, 1'b1);

    // Random phases, one per idling mode; phase two runs with zero ticks per
    // phase, which the block treats as one.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      configure((ph == 2) ? 16'd0 : PHASE_W'($urandom_range(1, 3)),
                POLL_W'($urandom_range(0, 4)));
      case (ph)
        0: set_idling(0, 0);
        1: set_idling(58, 0);
        2: set_idling(0, 58);
        default: set_idling(33, 33);
      endcase
      sda_low_pct = (ph % 2 == 0) ? 50 : 25;
      repeat (RANDOM_TICKS) random_tick();
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb_i2c_master_byte_engine_unit: clean");
    end else begin
      $display("tb_i2c_master_byte_engine_unit: errors");
    end
    $finish;
  end

endmodule

// File: i2c_master_byte_engine_unit.f
src/i2cm_pkg.sv
src/i2cm_front.sv
src/i2cm_seq.sv
src/i2cm_outq.sv
src/i2c_master_byte_engine_unit.sv
src/i2cm_checker.sv
tb/sv/i2cm_tick_checker.sv
tb/sv/tb_i2c_master_byte_engine_unit.sv
